@@ hw/rtl/sbus_frame_decoder_core_macros.svh @@
// Assertion macros used by the SBUS frame decoder top level.
`ifndef SBUS_FRAME_DECODER_CORE_MACROS_SVH
`define SBUS_FRAME_DECODER_CORE_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define SBUS_FD_ASSERT(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define SBUS_FD_ASSERT_IMP(name, trig, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

`endif

@@ hw/rtl/sbus_fd_pkg.sv @@
// Types and constants of the SBUS frame decoder.
package sbus_fd_pkg;

	localparam int unsigned FRAME_LEN = 25;
	localparam logic [4:0] FRAME_LAST = 5'd24;
	localparam logic [7:0] FRAME_HEAD = 8'h0f;
	localparam int unsigned CHANNELS = 16;
	localparam int unsigned CHAN_W = 11;
	localparam int unsigned PAYLOAD_BYTES = 23;
	localparam int unsigned PAYLOAD_W = 8 * PAYLOAD_BYTES;

	localparam logic [15:0] GAP_THRESHOLD_RESET = 16'd2000;
	localparam logic [7:0] DECODE_EVERY_RESET = 8'd20;

	typedef enum logic [0:0] {
		REG_GAP_THRESHOLD = 1'b0,
		REG_DECODE_EVERY  = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [15:0] gap_us;
	} rx_word_t;

	typedef struct packed {
		logic [3:0]  channel_index;
		logic [10:0] channel_value;
		logic [7:0]  flag_byte;
		logic [31:0] frame_count;
		logic        last;
	} res_word_t;

	// Bytes 1..23 of a frame, byte 1 in the low bits, and its frame count.
	typedef struct packed {
		logic [31:0]          frame_count;
		logic [PAYLOAD_W-1:0] payload;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ hw/rtl/sbus_fd_front.sv @@
// Front end: frame assembly, validity check and decimation.
module sbus_fd_front
	import sbus_fd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  rx_word_t    rx_word,
	input  logic [15:0] gap_threshold,
	input  logic [7:0]  decode_every,
	input  q_stat_t     q_stat,
	output logic        push,
	output frame_t      push_frame
);

	logic [4:0]  pos_q;
	logic [7:0]  store_q [FRAME_LEN];
	logic [31:0] frames_q;
	logic [7:0]  dec_q;

	logic        accept;
	logic [4:0]  pos_n;
	logic        in_frame;
	logic [7:0]  head;
	logic        frame_end;
	logic [7:0]  dec_n;
	logic        hit;

	assign rx_ready = !q_stat.full;
	assign accept   = rx_valid && rx_ready;

	always_comb begin
		pos_n = pos_q + 5'd1;
		if (rx_word.gap_us > gap_threshold) begin
			pos_n = 5'd0;
		end
	end

	assign in_frame  = pos_n < 5'(FRAME_LEN);
	assign head      = (pos_n == 5'd0) ? rx_word.rx_byte : store_q[0];
	assign frame_end = accept && (pos_n == FRAME_LAST) && (head == FRAME_HEAD);
	assign dec_n     = dec_q + 8'd1;
	assign hit       = dec_n >= decode_every;
	assign push      = frame_end && hit;

	always_comb begin
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			push_frame.payload[8*i +: 8] = store_q[i+1];
		end
		push_frame.frame_count = frames_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			frames_q <= '0;
			dec_q    <= '0;
			for (int i = 0; i < FRAME_LEN; i++) begin
				store_q[i] <= '0;
			end
		end else if (accept) begin
			// drop the byte and restart when the frame has overrun
			pos_q <= in_frame ? pos_n : 5'd0;
			for (int i = 0; i < FRAME_LEN; i++) begin
				if (in_frame && pos_n == 5'(i)) begin
					store_q[i] <= rx_word.rx_byte;
				end
			end
			if (frame_end) begin
				frames_q <= frames_q + 32'd1;
				dec_q    <= hit ? 8'd0 : dec_n;
			end
		end
	end

endmodule

@@ hw/rtl/sbus_fd_queue.sv @@
// Frame queue between the front end and the channel unpacker.
module sbus_fd_queue
	import sbus_fd_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  frame_t  push_frame,
	input  logic    pop,
	output frame_t  head,
	output q_stat_t q_stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	frame_t        entry_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign head         = entry_q[rd_q];
	assign q_stat.full  = count_q == CW'(DEPTH);
	assign q_stat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/sbus_fd_back.sv @@
// Back end: unpack one channel per cycle into the result register, while a frame waits and res_ready allows.
module sbus_fd_back
	import sbus_fd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  frame_t    head,
	input  q_stat_t   q_stat,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_ready,
	output res_word_t res_word
);

	logic [3:0] ch_q;
	logic       valid_q;
	res_word_t  word_q;
	logic       load;

	assign load      = !q_stat.empty && (!valid_q || res_ready);
	assign pop       = load && (ch_q == 4'(CHANNELS - 1));
	assign res_valid = valid_q;
	assign res_word  = word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q.channel_index <= ch_q;
			word_q.channel_value <= head.payload[CHAN_W * ch_q +: CHAN_W];
			word_q.flag_byte     <= head.payload[PAYLOAD_W-8 +: 8];
			word_q.frame_count   <= head.frame_count;
			word_q.last          <= ch_q == 4'(CHANNELS - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				ch_q    <= ch_q + 4'd1;
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/sbus_frame_decoder_core.sv @@
// SBUS frame decoder top level: register port, front end, frame queue, unpacker.
// Path: a frame-closing byte is written into the frame queue, and the unpacker loads channel 0 into res_word.
// Throughput: one byte per cycle; a decoded frame streams 16 words, one per cycle while res_ready is
// high, paced by the single channel unpacker; bytes stall only while QUEUE_DEPTH frames wait.
// Reset: arst_n clears position, frame store, counters and queue at once;
// gap_threshold returns to 2000 and decode_every to 20.
`include "sbus_frame_decoder_core_macros.svh"

module sbus_frame_decoder_core
	import sbus_fd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  rx_word_t    rx_word,
	output logic        res_valid,
	input  logic        res_ready,
	output res_word_t   res_word
);

	logic [15:0] gap_threshold_q;
	logic [7:0]  decode_every_q;
	reg_index_t  reg_sel;
	logic        cfg_write;

	logic    push;
	logic    pop;
	frame_t  push_frame;
	frame_t  head;
	q_stat_t q_stat;

	assign pready    = 1'b1;
	assign reg_sel   = reg_index_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_threshold_q <= GAP_THRESHOLD_RESET;
			decode_every_q  <= DECODE_EVERY_RESET;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_GAP_THRESHOLD: gap_threshold_q <= pwdata[15:0];
				REG_DECODE_EVERY:  decode_every_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_GAP_THRESHOLD: prdata = {16'd0, gap_threshold_q};
			REG_DECODE_EVERY:  prdata = {24'd0, decode_every_q};
			default:           prdata = '0;
		endcase
	end

	sbus_fd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_ready      (rx_ready),
		.rx_word       (rx_word),
		.gap_threshold (gap_threshold_q),
		.decode_every  (decode_every_q),
		.q_stat        (q_stat),
		.push          (push),
		.push_frame    (push_frame)
	);

	sbus_fd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	sbus_fd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

	`SBUS_FD_ASSERT(a_no_push_when_full, !(push && q_stat.full && !pop),
		"frame pushed into full queue")
	`SBUS_FD_ASSERT_IMP(a_pop_not_empty, pop, !q_stat.empty,
		"frame popped from empty queue")
	`SBUS_FD_ASSERT_IMP(a_last_is_ch15, res_valid && res_word.last,
		res_word.channel_index == 4'hf, "last flag off the final channel")

endmodule

@@ tb/sbus_frame_check.sv @@
// Frame decoder checker: watches the register port and both streams, predicts channel words.
`timescale 1ns / 1ps

module sbus_frame_check
	import sbus_fd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        rx_valid,
	input  logic        rx_ready,
	input  rx_word_t    rx_word,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_word_t   res_word,
	output int          errors,
	output int          pending,
	output int          words_checked
);

	logic [15:0] gap_limit;
	logic [7:0]  decode_period;
	logic [7:0]  position;
	logic [7:0]  frame_bytes [FRAME_LEN];
	logic [31:0] frames_seen;
	logic [7:0]  decim;
	res_word_t   channel_words_due [$];

	task automatic advance_frame(input rx_word_t w);
		logic [8*FRAME_LEN-1:0] flat;
		res_word_t r;
		position = position + 8'd1;
		if (w.gap_us > gap_limit)
			position = '0;
		if (position >= FRAME_LEN) begin
			// overrun: drop the word and wait for position 1
			position = '0;
			return;
		end
		frame_bytes[position] = w.rx_byte;
		if (position != FRAME_LAST || frame_bytes[0] != FRAME_HEAD)
			return;
		frames_seen = frames_seen + 32'd1;
		decim = decim + 8'd1;
		if (decim < decode_period)
			return;
		decim = '0;
		for (int b = 0; b < FRAME_LEN; b++)
			flat[8*b +: 8] = frame_bytes[b];
		for (int ch = 0; ch < CHANNELS; ch++) begin
			r.channel_index = 4'(ch);
			r.channel_value = flat[8 + CHAN_W*ch +: CHAN_W];
			r.flag_byte = frame_bytes[23];
			r.frame_count = frames_seen;
			r.last = (ch == CHANNELS - 1);
			channel_words_due.push_back(r);
		end
	endtask

	task automatic compare_word(input res_word_t got);
		res_word_t want;
		if (channel_words_due.size() == 0) begin
			errors++;
			$error("channel word with none due: index %0d value %0d",
				got.channel_index, got.channel_value);
			return;
		end
		want = channel_words_due.pop_front();
		words_checked++;
		if (got.channel_index !== want.channel_index) begin
			errors++;
			$error("channel_index expected %0d got %0d", want.channel_index, got.channel_index);
		end
		if (got.channel_value !== want.channel_value) begin
			errors++;
			$error("channel_value expected %0d got %0d", want.channel_value, got.channel_value);
		end
		if (got.flag_byte !== want.flag_byte) begin
			errors++;
			$error("flag_byte expected %0h got %0h", want.flag_byte, got.flag_byte);
		end
		if (got.frame_count !== want.frame_count) begin
			errors++;
			$error("frame_count expected %0d got %0d", want.frame_count, got.frame_count);
		end
		if (got.last !== want.last) begin
			errors++;
			$error("last expected %0b got %0b", want.last, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit = GAP_THRESHOLD_RESET;
			decode_period = DECODE_EVERY_RESET;
			position = '0;
			for (int b = 0; b < FRAME_LEN; b++)
				frame_bytes[b] = '0;
			frames_seen = '0;
			decim = '0;
			channel_words_due.delete();
			errors = 0;
			pending = 0;
			words_checked = 0;
		end else begin
			// compare first: a word taken now can only belong to older bytes
			if (res_valid && res_ready)
				compare_word(res_word);
			if (rx_valid && rx_ready)
				advance_frame(rx_word);
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				case (reg_index_t'(paddr[2]))
				REG_GAP_THRESHOLD: gap_limit = pwdata[15:0];
				REG_DECODE_EVERY:  decode_period = pwdata[7:0];
				default: ;
				endcase
			end
			pending = channel_words_due.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// Top of the frame decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
	import sbus_fd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        rx_valid;
	logic        rx_ready;
	rx_word_t    rx_word;
	logic        res_valid;
	logic        res_ready;
	res_word_t   res_word;

	int          errors;
	int          pending;
	int          words_checked;
	int          bytes_sent;
	logic [15:0] gap_limit;
	bit          idle_on;
	bit          hold_req;

	sbus_frame_decoder_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.rx_valid(rx_valid), .rx_ready(rx_ready), .rx_word(rx_word),
		.res_valid(res_valid), .res_ready(res_ready), .res_word(res_word)
	);

	sbus_frame_check u_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.rx_valid(rx_valid), .rx_ready(rx_ready), .rx_word(rx_word),
		.res_valid(res_valid), .res_ready(res_ready), .res_word(res_word),
		.errors(errors), .pending(pending), .words_checked(words_checked)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#4_000_000;
		$display("sbus_frame_decoder_core verification failed");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ready = 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
				res_ready = 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				res_ready = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				res_ready = 1'b1;
			end else begin
				res_ready = 1'b1;
			end
		end
	end

	function automatic logic [15:0] lead_gap();
		if (gap_limit == 16'hffff)
			return 16'hffff;
		if ($urandom_range(0, 3) == 0)
			return gap_limit + 16'd1;
		return 16'($urandom_range(gap_limit + 1, 65535));
	endfunction

	function automatic logic [15:0] inner_gap();
		if ($urandom_range(0, 3) == 0)
			return gap_limit;
		return 16'($urandom_range(0, gap_limit));
	endfunction

	task automatic push_byte(input logic [7:0] data, input logic [15:0] gap);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			rx_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		rx_word.rx_byte = data;
		rx_word.gap_us = gap;
		rx_valid = 1'b1;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// frame head after a long gap, then random bytes at short gaps
	task automatic send_frame(input int len);
		push_byte(FRAME_HEAD, lead_gap());
		for (int i = 1; i < len; i++)
			push_byte(8'($urandom), inner_gap());
	endtask

	// hold the stream until every channel word is back, then let the block settle
	task automatic wait_drain();
		rx_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic reg_write(input reg_index_t idx, input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx == REG_GAP_THRESHOLD)
			gap_limit = value[15:0];
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_valid = 1'b0;
		rx_word = '0;
		bytes_sent = 0;
		gap_limit = GAP_THRESHOLD_RESET;
		idle_on = 1'b1;
		hold_req = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// one frame at reset settings counts but stays below the decode period
		send_frame(FRAME_LEN);

		// period lowered to the running count, zero threshold; upper bits carry junk
		wait_drain();
		reg_write(REG_GAP_THRESHOLD, {16'($urandom), 16'd0});
		reg_write(REG_DECODE_EVERY, 32'hffff_ff01);

		// long receiver hold-off while frames keep coming: the block must back up
		hold_req = 1'b1;
		send_frame(FRAME_LEN + 2);
		send_frame(FRAME_LEN);
		send_frame(10);

		// no idling from here on: widest threshold, every frame decodes
		wait_drain();
		idle_on = 1'b0;
		reg_write(REG_GAP_THRESHOLD, {16'($urandom), 16'hffff});
		reg_write(REG_DECODE_EVERY, {24'($urandom), 8'd0});
		send_frame(FRAME_LEN);

		rx_valid = 1'b0;
		for (int i = 0; i < 5000 && pending != 0; i++)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("Covered %0d bytes and %0d channel words checked,", bytes_sent, words_checked);
		$display("thresholds 0, 2000 and 65535, periods 20, 1 and 0, overruns and a full stall.");
		if (errors == 0 && pending == 0)
			$display("sbus_frame_decoder_core verification clean");
		else
			$display("sbus_frame_decoder_core verification failed");
		$finish;
	end

endmodule
